// ===== rtl/histogram_match_map_defines.svh =====
// ----------------------------------------------------------------------------
// histogram_match_map_defines
// Assertion macros used by the histogram match map control module.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_MATCH_MAP_DEFINES_SVH
`define HISTOGRAM_MATCH_MAP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HMM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define HMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hmm_pkg.sv =====
// ----------------------------------------------------------------------------
// hmm_pkg
// Types and constants of the histogram match map block.
// ----------------------------------------------------------------------------
package hmm_pkg;

   localparam int BIN_COUNT = 256;
   localparam int BIN_W     = $clog2(BIN_COUNT);
   localparam int PTR_W     = BIN_W + 1;
   localparam int CNT_W     = BIN_W + 2;
   localparam int COUNT_W   = 24;
   localparam int WEIGHT_W  = 16;
   localparam int GROUP_W   = BIN_W - 2;
   localparam int MAP_W     = 8;
   localparam int TAP_W     = 17;
   localparam int TAP_COUNT = 4;
   localparam int HALF      = 3;
   localparam int BLUR_LEN  = BIN_COUNT + 2 * HALF;

   // cumulative sums of the six-times smoothed histograms
   localparam int SUM_S_W   = COUNT_W + BIN_W + 3;
   localparam int SUM_T_W   = WEIGHT_W + BIN_W + 3;
   localparam int LO_W      = (SUM_S_W + 1) / 2;
   localparam int HI_W      = SUM_S_W - LO_W;
   localparam int PROD_W    = SUM_S_W + SUM_T_W;

   localparam int BACC_W    = TAP_W + MAP_W + 4;
   localparam int ROUND_SH  = 16;

   localparam logic [MAP_W-1:0] MAP_MAX = '1;

   localparam logic [TAP_W-1:0] TAP_CENTER_RST = TAP_W'(9550);
   localparam logic [TAP_W-1:0] TAP_ONE_RST    = TAP_W'(9502);
   localparam logic [TAP_W-1:0] TAP_TWO_RST    = TAP_W'(9361);
   localparam logic [TAP_W-1:0] TAP_THREE_RST  = TAP_W'(9130);

   // register indexes of the configuration port
   localparam logic [1:0] CSR_CENTER = 2'd0;
   localparam logic [1:0] CSR_ONE    = 2'd1;
   localparam logic [1:0] CSR_TWO    = 2'd2;
   localparam logic [1:0] CSR_THREE  = 2'd3;

   typedef logic [TAP_COUNT-1:0][TAP_W-1:0] tap_array_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMOOTH,
      ST_CHECK,
      ST_W_READ,
      ST_W_MUL,
      ST_W_CMP,
      ST_FILL,
      ST_BLUR,
      ST_EMPTY,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic               load_en;
      logic [BIN_W-1:0]   load_addr;
      logic               sm_rd;
      logic [BIN_W-1:0]   sm_addr;
      logic               sm_clear;
      logic               sm_shift;
      logic               sm_step;
      logic               sm_first;
      logic               sm_last;
      logic [BIN_W-1:0]   sm_waddr;
      logic               walk_rd;
      logic [BIN_W-1:0]   i_addr;
      logic [BIN_W-1:0]   j_addr;
      logic               walk_mul;
      logic               map_wr;
      logic [BIN_W-1:0]   map_addr;
      logic [MAP_W-1:0]   map_data;
      logic               blur_start;
      logic               blur_rd;
      logic [BIN_W-1:0]   blur_addr;
      logic               emit_empty;
      logic [GROUP_W-1:0] emit_group;
   } cmd_type;

   typedef struct packed {
      logic cmp_le;
      logic empty;
      logic last_out;
   } status_type;

endpackage

// ===== rtl/hmm_datapath.sv =====
// ----------------------------------------------------------------------------
// hmm_datapath
// Bin stores, smoothing accumulators, cross-multiply compare, map store,
// seven-tap blur pipeline and the result register.
// ----------------------------------------------------------------------------
module hmm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  hmm_pkg::cmd_type                    cmd,
   output hmm_pkg::status_type                 status,
   input  hmm_pkg::tap_array_type              taps,
   input  logic [hmm_pkg::COUNT_W-1:0]         load_count,
   input  logic [hmm_pkg::WEIGHT_W-1:0]        load_weight,
   output logic                                rsp_strobe,
   output logic [hmm_pkg::GROUP_W-1:0]         rsp_group_index,
   output logic [hmm_pkg::MAP_W-1:0]           rsp_map_entry_0,
   output logic [hmm_pkg::MAP_W-1:0]           rsp_map_entry_1,
   output logic [hmm_pkg::MAP_W-1:0]           rsp_map_entry_2,
   output logic [hmm_pkg::MAP_W-1:0]           rsp_map_entry_3,
   output logic                                rsp_empty_histogram,
   output logic                                rsp_last_group
);

   localparam int SV_W = hmm_pkg::SUM_S_W;
   localparam int TV_W = hmm_pkg::SUM_T_W;
   localparam int BP_W = hmm_pkg::TAP_W + hmm_pkg::MAP_W + 1;

   logic [hmm_pkg::COUNT_W-1:0]  src_mem [hmm_pkg::BIN_COUNT];
   logic [hmm_pkg::WEIGHT_W-1:0] tgt_mem [hmm_pkg::BIN_COUNT];
   logic [SV_W-1:0]              cum_s_mem [hmm_pkg::BIN_COUNT];
   logic [TV_W-1:0]              cum_t_mem [hmm_pkg::BIN_COUNT];
   logic [hmm_pkg::MAP_W-1:0]    map_mem [hmm_pkg::BIN_COUNT];

   logic [hmm_pkg::COUNT_W-1:0]  src_q_ff, s_p1_ff, s_p2_ff;
   logic [hmm_pkg::WEIGHT_W-1:0] tgt_q_ff, t_p1_ff, t_p2_ff;
   logic [SV_W-1:0]              acc_s_ff, acc_s_in, sv;
   logic [TV_W-1:0]              acc_t_ff, acc_t_in, tv;

   logic [SV_W-1:0]              cs_q_ff;
   logic [TV_W-1:0]              ct_q_ff;
   logic [hmm_pkg::LO_W+TV_W-1:0] pl_ff, ql_ff;
   logic [hmm_pkg::HI_W+TV_W-1:0] ph_ff, qh_ff;
   logic [hmm_pkg::PROD_W-1:0]   lhs, rhs;

   logic                         rd_valid_ff, win_valid_ff, a_valid_ff;
   logic [hmm_pkg::MAP_W-1:0]    map_q_ff;
   logic [hmm_pkg::MAP_W-1:0]    win_ff [7];
   logic [2:0]                   fill_ff;
   logic [hmm_pkg::BIN_W-1:0]    k_ff;
   logic [BP_W-1:0]              bp_ff [hmm_pkg::TAP_COUNT];
   logic [hmm_pkg::BACC_W-1:0]   bsum;
   logic [hmm_pkg::BACC_W-hmm_pkg::ROUND_SH-1:0] bshift;
   logic [hmm_pkg::MAP_W-1:0]    bres;
   logic [hmm_pkg::MAP_W-1:0]    lane_ff [3];

   logic                         rsp_strobe_ff, rsp_empty_ff, rsp_last_ff;
   logic [hmm_pkg::GROUP_W-1:0]  rsp_group_ff;
   logic [hmm_pkg::MAP_W-1:0]    rsp_e_ff [4];

   // bin load and smoothing reads
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         src_mem[cmd.load_addr] <= load_count;
         tgt_mem[cmd.load_addr] <= load_weight;
      end
      if (cmd.sm_rd) begin
         src_q_ff <= src_mem[cmd.sm_addr];
         tgt_q_ff <= tgt_mem[cmd.sm_addr];
      end
      if (cmd.sm_shift) begin
         s_p1_ff <= src_q_ff;
         s_p2_ff <= s_p1_ff;
         t_p1_ff <= tgt_q_ff;
         t_p2_ff <= t_p1_ff;
      end
   end

   // box smoothing scaled by six
   always_comb begin
      if (cmd.sm_first) begin
         sv = SV_W'(3) * (SV_W'(s_p1_ff) + SV_W'(src_q_ff));
         tv = TV_W'(3) * (TV_W'(t_p1_ff) + TV_W'(tgt_q_ff));
      end else if (cmd.sm_last) begin
         sv = SV_W'(3) * (SV_W'(s_p2_ff) + SV_W'(s_p1_ff));
         tv = TV_W'(3) * (TV_W'(t_p2_ff) + TV_W'(t_p1_ff));
      end else begin
         sv = SV_W'(2) * (SV_W'(s_p2_ff) + SV_W'(s_p1_ff) + SV_W'(src_q_ff));
         tv = TV_W'(2) * (TV_W'(t_p2_ff) + TV_W'(t_p1_ff) + TV_W'(tgt_q_ff));
      end
      acc_s_in = acc_s_ff + sv;
      acc_t_in = acc_t_ff + tv;
   end

   // running sums, written to the cumulative stores
   always_ff @(posedge clock) begin
      if (cmd.sm_clear) begin
         acc_s_ff <= '0;
         acc_t_ff <= '0;
      end else if (cmd.sm_step) begin
         acc_s_ff <= acc_s_in;
         acc_t_ff <= acc_t_in;
         cum_s_mem[cmd.sm_waddr] <= acc_s_in;
         cum_t_mem[cmd.sm_waddr] <= acc_t_in;
      end
   end

   // cross-multiply compare, products split in halves
   always_ff @(posedge clock) begin
      if (cmd.walk_rd) begin
         cs_q_ff <= cum_s_mem[cmd.i_addr];
         ct_q_ff <= cum_t_mem[cmd.j_addr];
      end
      if (cmd.walk_mul) begin
         pl_ff <= cs_q_ff[hmm_pkg::LO_W-1:0] * acc_t_ff;
         ph_ff <= cs_q_ff[SV_W-1:hmm_pkg::LO_W] * acc_t_ff;
         ql_ff <= ct_q_ff * acc_s_ff[hmm_pkg::LO_W-1:0];
         qh_ff <= ct_q_ff * acc_s_ff[SV_W-1:hmm_pkg::LO_W];
      end
   end

   assign lhs = (hmm_pkg::PROD_W'(ph_ff) << hmm_pkg::LO_W) + hmm_pkg::PROD_W'(pl_ff);
   assign rhs = (hmm_pkg::PROD_W'(qh_ff) << hmm_pkg::LO_W) + hmm_pkg::PROD_W'(ql_ff);

   // raw map store and blur window
   always_ff @(posedge clock) begin
      if (cmd.map_wr) begin
         map_mem[cmd.map_addr] <= cmd.map_data;
      end
      if (cmd.blur_rd) begin
         map_q_ff <= map_mem[cmd.blur_addr];
      end
      if (rd_valid_ff) begin
         for (int n = 0; n < 6; n++) begin
            win_ff[n] <= win_ff[n+1];
         end
         win_ff[6] <= map_q_ff;
      end
   end

   // blur products
   always_ff @(posedge clock) begin
      if (win_valid_ff) begin
         bp_ff[0] <= BP_W'(taps[0]) * BP_W'(win_ff[3]);
         bp_ff[1] <= BP_W'(taps[1]) * BP_W'({1'b0, win_ff[2]} + {1'b0, win_ff[4]});
         bp_ff[2] <= BP_W'(taps[2]) * BP_W'({1'b0, win_ff[1]} + {1'b0, win_ff[5]});
         bp_ff[3] <= BP_W'(taps[3]) * BP_W'({1'b0, win_ff[0]} + {1'b0, win_ff[6]});
      end
   end

   // rounding and saturation
   always_comb begin
      bsum = hmm_pkg::BACC_W'(bp_ff[0]) + hmm_pkg::BACC_W'(bp_ff[1]) +
             hmm_pkg::BACC_W'(bp_ff[2]) + hmm_pkg::BACC_W'(bp_ff[3]) +
             hmm_pkg::BACC_W'(1 << (hmm_pkg::ROUND_SH - 1));
      bshift = bsum[hmm_pkg::BACC_W-1:hmm_pkg::ROUND_SH];
      bres = (bshift > hmm_pkg::MAP_MAX) ? hmm_pkg::MAP_MAX : bshift[hmm_pkg::MAP_W-1:0];
   end

   // blur pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
         fill_ff      <= '0;
         k_ff         <= '0;
      end else begin
         rd_valid_ff  <= cmd.blur_rd;
         win_valid_ff <= rd_valid_ff && (fill_ff >= 3'd6);
         a_valid_ff   <= win_valid_ff;
         if (cmd.blur_start) begin
            fill_ff <= '0;
            k_ff    <= '0;
         end else begin
            if (rd_valid_ff && fill_ff != 3'd7) begin
               fill_ff <= fill_ff + 3'd1;
            end
            if (a_valid_ff) begin
               k_ff <= k_ff + 1'b1;
            end
         end
      end
   end

   // lane collection
   always_ff @(posedge clock) begin
      if (a_valid_ff && k_ff[1:0] != 2'd3) begin
         lane_ff[k_ff[1:0]] <= bres;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_empty || (a_valid_ff && k_ff[1:0] == 2'd3);
      end
      if (cmd.emit_empty) begin
         rsp_group_ff <= cmd.emit_group;
         rsp_empty_ff <= 1'b1;
         rsp_last_ff  <= &cmd.emit_group;
         for (int n = 0; n < 4; n++) begin
            rsp_e_ff[n] <= hmm_pkg::MAP_MAX;
         end
      end else if (a_valid_ff && k_ff[1:0] == 2'd3) begin
         rsp_group_ff <= k_ff[hmm_pkg::BIN_W-1:2];
         rsp_empty_ff <= 1'b0;
         rsp_last_ff  <= &k_ff[hmm_pkg::BIN_W-1:2];
         rsp_e_ff[0]  <= lane_ff[0];
         rsp_e_ff[1]  <= lane_ff[1];
         rsp_e_ff[2]  <= lane_ff[2];
         rsp_e_ff[3]  <= bres;
      end
   end

   assign status.cmp_le   = (lhs <= rhs);
   assign status.empty    = (acc_s_ff == '0) || (acc_t_ff == '0);
   assign status.last_out = rsp_strobe_ff && rsp_last_ff;

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_group_index     = rsp_group_ff;
   assign rsp_map_entry_0     = rsp_e_ff[0];
   assign rsp_map_entry_1     = rsp_e_ff[1];
   assign rsp_map_entry_2     = rsp_e_ff[2];
   assign rsp_map_entry_3     = rsp_e_ff[3];
   assign rsp_empty_histogram = rsp_empty_ff;
   assign rsp_last_group      = rsp_last_ff;

endmodule

// ===== rtl/hmm_control.sv =====
// ----------------------------------------------------------------------------
// hmm_control
// Sequencer: load, smoothing sweep, matching walk, fill, blur sweep, output.
// ----------------------------------------------------------------------------
`include "histogram_match_map_defines.svh"

module hmm_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 final_bin,
   output logic                 busy,
   output hmm_pkg::cmd_type     cmd,
   input  hmm_pkg::status_type  status
);

   localparam int BN = hmm_pkg::BIN_COUNT;

   hmm_pkg::state_type             state_ff, state_in;
   logic [hmm_pkg::BIN_W-1:0]      pos_ff, pos_in;
   logic [hmm_pkg::CNT_W-1:0]      cnt_ff, cnt_in, refl;
   logic [hmm_pkg::PTR_W-1:0]      i_ff, i_in, j_ff, j_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmm_pkg::ST_IDLE;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   // reflect-101 index of the blur stream
   always_comb begin
      if (cnt_ff < hmm_pkg::CNT_W'(hmm_pkg::HALF)) begin
         refl = hmm_pkg::CNT_W'(hmm_pkg::HALF) - cnt_ff;
      end else if (cnt_ff >= hmm_pkg::CNT_W'(BN + hmm_pkg::HALF)) begin
         refl = hmm_pkg::CNT_W'(2 * BN + 1) - cnt_ff;
      end else begin
         refl = cnt_ff - hmm_pkg::CNT_W'(hmm_pkg::HALF);
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      busy     = 1'b1;
      cmd      = '0;
      cmd.load_addr  = pos_ff;
      cmd.sm_addr    = cnt_ff[hmm_pkg::BIN_W-1:0];
      cmd.sm_waddr   = hmm_pkg::BIN_W'(cnt_ff - hmm_pkg::CNT_W'(2));
      cmd.i_addr     = i_ff[hmm_pkg::BIN_W-1:0];
      cmd.j_addr     = j_ff[hmm_pkg::BIN_W-1:0];
      cmd.map_addr   = i_ff[hmm_pkg::BIN_W-1:0];
      cmd.map_data   = hmm_pkg::MAP_MAX;
      cmd.blur_addr  = refl[hmm_pkg::BIN_W-1:0];
      cmd.emit_group = cnt_ff[hmm_pkg::GROUP_W-1:0];
      unique case (state_ff)
         hmm_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_en = 1'b1;
               if (final_bin) begin
                  pos_in   = '0;
                  cnt_in   = '0;
                  state_in = hmm_pkg::ST_SMOOTH;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         hmm_pkg::ST_SMOOTH: begin
            cmd.sm_rd    = (cnt_ff < hmm_pkg::CNT_W'(BN));
            cmd.sm_clear = (cnt_ff == '0);
            cmd.sm_shift = (cnt_ff >= hmm_pkg::CNT_W'(1)) &&
                           (cnt_ff <= hmm_pkg::CNT_W'(BN));
            cmd.sm_step  = (cnt_ff >= hmm_pkg::CNT_W'(2));
            cmd.sm_first = (cnt_ff == hmm_pkg::CNT_W'(2));
            cmd.sm_last  = (cnt_ff == hmm_pkg::CNT_W'(BN + 1));
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hmm_pkg::CNT_W'(BN + 1)) begin
               state_in = hmm_pkg::ST_CHECK;
            end
         end
         hmm_pkg::ST_CHECK: begin
            cnt_in = '0;
            i_in   = '0;
            j_in   = '0;
            state_in = status.empty ? hmm_pkg::ST_EMPTY : hmm_pkg::ST_W_READ;
         end
         hmm_pkg::ST_W_READ: begin
            cmd.walk_rd = 1'b1;
            state_in = hmm_pkg::ST_W_MUL;
         end
         hmm_pkg::ST_W_MUL: begin
            cmd.walk_mul = 1'b1;
            state_in = hmm_pkg::ST_W_CMP;
         end
         hmm_pkg::ST_W_CMP: begin
            if (status.cmp_le) begin
               cmd.map_wr   = 1'b1;
               cmd.map_data = j_ff[hmm_pkg::BIN_W-1:0];
               i_in = i_ff + 1'b1;
               if (i_ff == hmm_pkg::PTR_W'(BN - 1)) begin
                  cmd.blur_start = 1'b1;
                  cnt_in   = '0;
                  state_in = hmm_pkg::ST_BLUR;
               end else begin
                  state_in = hmm_pkg::ST_W_READ;
               end
            end else begin
               j_in = j_ff + 1'b1;
               state_in = (j_ff == hmm_pkg::PTR_W'(BN - 1)) ? hmm_pkg::ST_FILL
                                                          : hmm_pkg::ST_W_READ;
            end
         end
         hmm_pkg::ST_FILL: begin
            cmd.map_wr = 1'b1;
            i_in = i_ff + 1'b1;
            if (i_ff == hmm_pkg::PTR_W'(BN - 1)) begin
               cmd.blur_start = 1'b1;
               cnt_in   = '0;
               state_in = hmm_pkg::ST_BLUR;
            end
         end
         hmm_pkg::ST_BLUR: begin
            cmd.blur_rd = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hmm_pkg::CNT_W'(hmm_pkg::BLUR_LEN - 1)) begin
               state_in = hmm_pkg::ST_DRAIN;
            end
         end
         hmm_pkg::ST_EMPTY: begin
            cmd.emit_empty = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == hmm_pkg::CNT_W'(BN / 4 - 1)) begin
               state_in = hmm_pkg::ST_DRAIN;
            end
         end
         hmm_pkg::ST_DRAIN: begin
            if (status.last_out) begin
               state_in = hmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hmm_pkg::ST_IDLE;
         end
      endcase
   end

   // checks
   `HMM_ASSERT_NOW(a_walk_ptrs, clock, reset, state_ff == hmm_pkg::ST_W_READ, !i_ff[hmm_pkg::BIN_W] && !j_ff[hmm_pkg::BIN_W], "walk pointer out of range")
   `HMM_ASSERT_NOW(a_smooth_pos, clock, reset, state_ff == hmm_pkg::ST_SMOOTH, pos_ff == '0, "load position not cleared at final bin")
   `HMM_ASSERT_NEXT(a_cmp_order, clock, reset, state_ff == hmm_pkg::ST_W_MUL, state_ff == hmm_pkg::ST_W_CMP, "compare step out of order")

endmodule

// ===== rtl/histogram_match_map.sv =====
// ----------------------------------------------------------------------------
// histogram_match_map
// Histogram matching gray map: smoothed cumulative match, seven-tap blur.
// ----------------------------------------------------------------------------
// Usage: send 256 bins, one per cycle, by raising start with req_source_count
// and req_target_weight while busy is low; bins go to consecutive positions.
// A bin with req_final_bin high is stored and starts the computation, and the
// load position returns to zero.
// After the final bin the block is busy: a smoothing sweep, a matching walk
// of at most 511 steps, each a read, a multiply into registered cross
// products and a compare of them, a fill of unmatched bins, and a blur sweep
// through map read, window, product and round/result register stages.
// Results appear on rsp_* with rsp_strobe high for one cycle, one group of
// four map entries per strobe, rsp_last_group on group 63; busy falls after
// it. With an empty histogram the 64 groups come one per cycle, all 255.
// Reset clears the sequencer and load position and restores the blur taps;
// the bin stores are not cleared. Results cannot be held off by the receiver.
// csr_* writes set the four Q16 blur taps and are to be done by the user
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module histogram_match_map (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [hmm_pkg::COUNT_W-1:0]     req_source_count,
   input  logic [hmm_pkg::WEIGHT_W-1:0]    req_target_weight,
   input  logic                            req_final_bin,
   output logic                            rsp_strobe,
   output logic [hmm_pkg::GROUP_W-1:0]     rsp_group_index,
   output logic [hmm_pkg::MAP_W-1:0]       rsp_map_entry_0,
   output logic [hmm_pkg::MAP_W-1:0]       rsp_map_entry_1,
   output logic [hmm_pkg::MAP_W-1:0]       rsp_map_entry_2,
   output logic [hmm_pkg::MAP_W-1:0]       rsp_map_entry_3,
   output logic                            rsp_empty_histogram,
   output logic                            rsp_last_group,
   input  logic                            csr_write_en,
   input  logic [1:0]                      csr_index,
   input  logic [hmm_pkg::TAP_W-1:0]       csr_wdata
);

   hmm_pkg::tap_array_type taps_ff;
   hmm_pkg::cmd_type       cmd;
   hmm_pkg::status_type    status;

   // blur tap registers
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff[0] <= hmm_pkg::TAP_CENTER_RST;
         taps_ff[1] <= hmm_pkg::TAP_ONE_RST;
         taps_ff[2] <= hmm_pkg::TAP_TWO_RST;
         taps_ff[3] <= hmm_pkg::TAP_THREE_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            hmm_pkg::CSR_CENTER: taps_ff[0] <= csr_wdata;
            hmm_pkg::CSR_ONE:    taps_ff[1] <= csr_wdata;
            hmm_pkg::CSR_TWO:    taps_ff[2] <= csr_wdata;
            hmm_pkg::CSR_THREE:  taps_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   hmm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .final_bin (req_final_bin),
      .busy      (busy),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath
   hmm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .taps                (taps_ff),
      .load_count          (req_source_count),
      .load_weight         (req_target_weight),
      .rsp_strobe          (rsp_strobe),
      .rsp_group_index     (rsp_group_index),
      .rsp_map_entry_0     (rsp_map_entry_0),
      .rsp_map_entry_1     (rsp_map_entry_1),
      .rsp_map_entry_2     (rsp_map_entry_2),
      .rsp_map_entry_3     (rsp_map_entry_3),
      .rsp_empty_histogram (rsp_empty_histogram),
      .rsp_last_group      (rsp_last_group)
   );

endmodule
